/* hw/rtl/nvme_block_command_translator_macros.svh */
// Assertion macros used by the translator's top-level RTL file.
`ifndef NVME_BLOCK_COMMAND_TRANSLATOR_MACROS_SVH
`define NVME_BLOCK_COMMAND_TRANSLATOR_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define NBCT_ASSERT_NOW(label, clk, rst_n, cond, conseq, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (conseq)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define NBCT_ASSERT_NEXT(label, clk, rst_n, cond, conseq, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (conseq)) \
        else $error(msg);

`endif

/* hw/rtl/nbct_pkg.sv */
// Shared constants and types of the NVMe block command translator.
package nbct_pkg;

    localparam int SLOTS      = 1024;
    localparam int MAX_BLOCKS = 64;
    localparam int SLOT_W     = $clog2(SLOTS);

    localparam logic [63:0] PRP_LIST_BASE_RESET = 64'h0000_0000_5FFF_4000;
    localparam logic [63:0] PAGE_BYTES          = 64'h0000_0000_0000_1000;
    localparam logic [31:0] LIMITED_RETRY       = 32'h8000_0000;

    localparam logic [7:0] OPC_READ  = 8'h02;
    localparam logic [7:0] OPC_WRITE = 8'h01;

    localparam logic       ACT_REQUEST    = 1'b0;
    localparam logic       ACT_COMPLETION = 1'b1;
    localparam logic [1:0] REQ_READ       = 2'd0;
    localparam logic [1:0] REQ_WRITE      = 2'd1;

    typedef enum logic [1:0] {
        KIND_CMD  = 2'd0,
        KIND_LIST = 2'd1,
        KIND_RESP = 2'd2
    } t_kind;

    typedef struct packed {
        logic [31:0] request_id;
        logic [6:0]  block_count;
    } t_slot_entry;

    typedef struct packed {
        t_kind       kind;
        logic [31:0] command_word0;
        logic [63:0] start_lba;
        logic [31:0] range_word;
        logic [63:0] first_pointer;
        logic [63:0] second_pointer;
        logic [5:0]  list_index;
        logic [63:0] list_value;
        logic        resp_error;
        logic [6:0]  resp_count;
        logic [31:0] resp_id;
        logic        last;
    } t_out_beat;

endpackage

/* hw/rtl/nbct_if.sv */
// Valid/ready channel interfaces for request beats and result beats.
interface nbct_in_if;
    import nbct_pkg::*;
    logic        valid;
    logic        ready;
    logic        action;
    logic [1:0]  req_code;
    logic [63:0] buffer_addr;
    logic [60:0] first_block;
    logic [6:0]  block_count;
    logic [31:0] request_id;
    logic [9:0]  completion_slot;
    logic [14:0] completion_status;

    modport source (
        output valid, action, req_code, buffer_addr, first_block, block_count,
               request_id, completion_slot, completion_status,
        input  ready
    );
    modport sink (
        input  valid, action, req_code, buffer_addr, first_block, block_count,
               request_id, completion_slot, completion_status,
        output ready
    );
endinterface

interface nbct_out_if;
    import nbct_pkg::*;
    logic        valid;
    logic        ready;
    t_kind       kind;
    logic [31:0] command_word0;
    logic [63:0] start_lba;
    logic [31:0] range_word;
    logic [63:0] first_pointer;
    logic [63:0] second_pointer;
    logic [5:0]  list_index;
    logic [63:0] list_value;
    logic        resp_error;
    logic [6:0]  resp_count;
    logic [31:0] resp_id;
    logic        last;

    modport source (
        output valid, kind, command_word0, start_lba, range_word, first_pointer,
               second_pointer, list_index, list_value, resp_error, resp_count,
               resp_id, last,
        input  ready
    );
    modport sink (
        input  valid, kind, command_word0, start_lba, range_word, first_pointer,
               second_pointer, list_index, list_value, resp_error, resp_count,
               resp_id, last,
        output ready
    );
endinterface

/* hw/rtl/nvme_block_command_translator.sv */
// Top level: block requests to NVMe commands and completions to block responses.
//
// i_in carries one beat per block request or device completion; o_out carries
// result beats, and the final beat caused by an input has last set. i_cfg_we
// with i_cfg_wdata loads the PRP list base address; the user must write it only
// while idle, as the block itself does not enforce this. One input is handled
// at a time: i_in.ready is high only while no beat of the previous input
// remains to be produced. The result register lets the next input be accepted
// while the final result still waits on o_out. A completion first goes through
// a slot table lookup state. A request of N > 2 blocks first sends N-1 PRP list
// beats, one per cycle while o_out accepts them, then the command.
// Reset clears the command ID counter, the result valid flag and the list base
// (to its default); the slot table is not cleared, and a completion naming a
// slot never written returns arbitrary id and count. When o_out stalls, the
// sequencer holds its beat and no further input is taken.
module nvme_block_command_translator (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [63:0] i_cfg_wdata,
    nbct_in_if.sink     i_in,
    nbct_out_if.source  o_out
);
    import nbct_pkg::*;

    `include "nvme_block_command_translator_macros.svh"

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOOKUP,
        S_RESP,
        S_LIST,
        S_CMD
    } t_state;

    localparam int ENTRY_W = $bits(t_slot_entry);

    t_state            r_state;
    logic [SLOT_W-1:0] r_next_slot;
    logic [SLOT_W-1:0] n_next_slot;
    logic [63:0]       r_prp_list_base;
    logic [7:0]        r_opcode;
    logic [SLOT_W-1:0] r_slot;
    logic [60:0]       r_block;
    logic [6:0]        r_count;
    logic [63:0]       r_buf;
    logic [63:0]       r_lval;
    logic [5:0]        r_lidx;
    logic              r_resp_error;
    logic [6:0]        r_resp_count;
    logic [31:0]       r_resp_id;
    logic              r_c_oor;
    logic              r_c_err;
    logic              r_out_valid;
    t_out_beat         r_out;

    logic              in_fire;
    logic              out_free;
    logic              out_load;
    logic              is_data;
    logic              count_bad;
    logic              ram_we;
    logic              ram_re;
    t_slot_entry       wr_entry;
    t_slot_entry       rd_entry;
    logic [ENTRY_W-1:0] rd_bits;
    logic [9:0]        range_cnt;
    logic [6:0]        list_end;
    t_out_beat         beat_resp;
    t_out_beat         beat_list;
    t_out_beat         beat_cmd;

    assign in_fire   = i_in.valid && i_in.ready;
    assign out_free  = !r_out_valid || o_out.ready;
    assign out_load  = out_free &&
                       (r_state == S_RESP || r_state == S_LIST || r_state == S_CMD);
    assign is_data   = (i_in.action == ACT_REQUEST) &&
                       (i_in.req_code == REQ_READ || i_in.req_code == REQ_WRITE);
    assign count_bad = (i_in.block_count == 7'd0) ||
                       (i_in.block_count > 7'(MAX_BLOCKS));
    assign ram_we    = in_fire && is_data && !count_bad;
    assign ram_re    = in_fire && (i_in.action == ACT_COMPLETION);

    assign wr_entry.request_id  = i_in.request_id;
    assign wr_entry.block_count = i_in.block_count;
    assign rd_entry = t_slot_entry'(rd_bits);

    assign n_next_slot = (r_next_slot == SLOT_W'(SLOTS - 1)) ? '0 : r_next_slot + 1'b1;
    assign range_cnt   = {r_count, 3'b000} - 10'd1;
    assign list_end    = r_count - 7'd2;

    nbct_slot_ram #(
        .DEPTH (SLOTS),
        .WIDTH (ENTRY_W)
    ) u_slot_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_next_slot),
        .i_wdata (wr_entry),
        .i_re    (ram_re),
        .i_raddr (SLOT_W'(i_in.completion_slot)),
        .o_rdata (rd_bits)
    );

    always_comb begin
        beat_resp             = '0;
        beat_resp.kind        = KIND_RESP;
        beat_resp.resp_error  = r_resp_error;
        beat_resp.resp_count  = r_resp_count;
        beat_resp.resp_id     = r_resp_id;
        beat_resp.last        = 1'b1;

        beat_list            = '0;
        beat_list.kind       = KIND_LIST;
        beat_list.list_index = r_lidx;
        beat_list.list_value = r_lval;

        beat_cmd               = '0;
        beat_cmd.kind          = KIND_CMD;
        beat_cmd.command_word0 = {16'(r_slot), 8'h00, r_opcode};
        beat_cmd.start_lba     = {r_block, 3'b000};
        beat_cmd.range_word    = LIMITED_RETRY | 32'(range_cnt);
        beat_cmd.first_pointer = r_buf;
        if (r_count == 7'd2) begin
            beat_cmd.second_pointer = r_buf + PAGE_BYTES;
        end else if (r_count > 7'd2) begin
            beat_cmd.second_pointer = r_prp_list_base;
        end
        beat_cmd.last = 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= S_IDLE;
            r_next_slot     <= '0;
            r_out_valid     <= 1'b0;
            r_prp_list_base <= PRP_LIST_BASE_RESET;
        end else begin
            if (i_cfg_we) begin
                r_prp_list_base <= i_cfg_wdata;
            end
            if (o_out.ready && !out_load) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_fire) begin
                        r_buf    <= i_in.buffer_addr;
                        r_block  <= i_in.first_block;
                        r_count  <= i_in.block_count;
                        r_opcode <= (i_in.req_code == REQ_READ) ? OPC_READ : OPC_WRITE;
                        r_slot   <= r_next_slot;
                        r_lval   <= i_in.buffer_addr + PAGE_BYTES;
                        r_lidx   <= '0;
                        r_c_oor  <= (32'(i_in.completion_slot) >= 32'(SLOTS));
                        r_c_err  <= (i_in.completion_status != 15'd0);
                        r_resp_count <= '0;
                        r_resp_id    <= i_in.request_id;
                        if (i_in.action == ACT_COMPLETION) begin
                            r_state <= S_LOOKUP;
                        end else if (!is_data) begin
                            r_resp_error <= 1'b0;
                            r_state      <= S_RESP;
                        end else if (count_bad) begin
                            r_resp_error <= 1'b1;
                            r_state      <= S_RESP;
                        end else begin
                            r_next_slot <= n_next_slot;
                            r_state     <= (i_in.block_count > 7'd2) ? S_LIST : S_CMD;
                        end
                    end
                end
                S_LOOKUP: begin
                    r_resp_error  <= r_c_oor || r_c_err;
                    r_resp_count  <= (r_c_oor || r_c_err) ? 7'd0 : rd_entry.block_count;
                    r_resp_id     <= r_c_oor ? 32'd0 : rd_entry.request_id;
                    r_state       <= S_RESP;
                end
                S_RESP: begin
                    if (out_free) begin
                        r_out       <= beat_resp;
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                S_LIST: begin
                    if (out_free) begin
                        r_out       <= beat_list;
                        r_out_valid <= 1'b1;
                        r_lidx      <= r_lidx + 6'd1;
                        r_lval      <= r_lval + PAGE_BYTES;
                        // Entries cover pages 1 through count-1 of the buffer.
                        if (7'(r_lidx) == list_end) begin
                            r_state <= S_CMD;
                        end
                    end
                end
                S_CMD: begin
                    if (out_free) begin
                        r_out       <= beat_cmd;
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign i_in.ready           = (r_state == S_IDLE);
    assign o_out.valid          = r_out_valid;
    assign o_out.kind           = r_out.kind;
    assign o_out.command_word0  = r_out.command_word0;
    assign o_out.start_lba      = r_out.start_lba;
    assign o_out.range_word     = r_out.range_word;
    assign o_out.first_pointer  = r_out.first_pointer;
    assign o_out.second_pointer = r_out.second_pointer;
    assign o_out.list_index     = r_out.list_index;
    assign o_out.list_value     = r_out.list_value;
    assign o_out.resp_error     = r_out.resp_error;
    assign o_out.resp_count     = r_out.resp_count;
    assign o_out.resp_id        = r_out.resp_id;
    assign o_out.last           = r_out.last;

    `NBCT_ASSERT_NEXT(a_lookup_after_read, i_clk, i_rst_n, ram_re, r_state == S_LOOKUP, "completion did not enter slot lookup")
    `NBCT_ASSERT_NEXT(a_slot_advance, i_clk, i_rst_n, ram_we, r_next_slot != $past(r_next_slot), "command ID counter did not advance")
    `NBCT_ASSERT_NOW(a_list_bound, i_clk, i_rst_n, r_state == S_LIST, r_count > 7'd2 && 7'(r_lidx) <= list_end, "PRP list index ran past the request")
    `NBCT_ASSERT_NEXT(a_final_beat, i_clk, i_rst_n, out_load && (r_state == S_RESP || r_state == S_CMD), r_state == S_IDLE && r_out_valid && r_out.last, "final beat not marked last or sequencer not idle")

endmodule

/* hw/rtl/nbct_slot_ram.sv */
// Simple dual-port slot table RAM with one write port and a registered read port.
module nbct_slot_ram #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 39
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
